>>> rtl/svfc_pkg.sv
// Shared types, constants and helpers of the crossover filter coefficient calculator.
`timescale 1ns / 1ps
`default_nettype none
package svfc_pkg;

   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS  = COEF_WIDTH - 2;
   localparam int EMIT_UP    = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
   localparam int EMIT_DN    = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;

   localparam int FS_W    = 18;
   localparam int FREQ_W  = 17;
   localparam int FIELD_W = 32;

   localparam logic [1:0] FT_LR2  = 2'd0;
   localparam logic [1:0] FT_BW2  = 2'd1;
   localparam logic [1:0] FT_LR4  = 2'd2;
   localparam logic [1:0] FT_NONE = 2'd3;

   localparam logic [FS_W-1:0]   FS_RESET  = 18'd44100;
   localparam logic [FREQ_W-1:0] FREQ_MIN  = 17'd10;
   localparam logic [31:0]       PI_Q30    = 32'd3373259426;
   localparam logic [31:0]       SQRT2_Q30 = 32'd1518500250;
   localparam logic [31:0]       TWO_Q30   = 32'h8000_0000;
   localparam logic [30:0]       ONE_Q30   = 31'h4000_0000;

   // Pipelined divider geometry, sized for the largest of the three divisions.
   localparam int DIV_DW = 61;
   localparam int DIV_VW = 38;
   localparam int DIV_QW = 40;

   localparam int HR_STEPS = 7;

   // Reciprocals ceil(2^S/d) for the series divisors, S = 32 + ceil(log2 d).
   localparam int SIN_SH [HR_STEPS] = '{35, 37, 38, 39, 39, 40, 40};
   localparam int COS_SH [HR_STEPS] = '{33, 36, 37, 38, 39, 40, 40};
   localparam logic [32:0] SIN_RCP [HR_STEPS] = '{
      33'(((65'd1 << 35) + 65'd5) / 65'd6),
      33'(((65'd1 << 37) + 65'd19) / 65'd20),
      33'(((65'd1 << 38) + 65'd41) / 65'd42),
      33'(((65'd1 << 39) + 65'd71) / 65'd72),
      33'(((65'd1 << 39) + 65'd109) / 65'd110),
      33'(((65'd1 << 40) + 65'd155) / 65'd156),
      33'(((65'd1 << 40) + 65'd209) / 65'd210)};
   localparam logic [32:0] COS_RCP [HR_STEPS] = '{
      33'(((65'd1 << 33) + 65'd1) / 65'd2),
      33'(((65'd1 << 36) + 65'd11) / 65'd12),
      33'(((65'd1 << 37) + 65'd29) / 65'd30),
      33'(((65'd1 << 38) + 65'd55) / 65'd56),
      33'(((65'd1 << 39) + 65'd89) / 65'd90),
      33'(((65'd1 << 40) + 65'd131) / 65'd132),
      33'(((65'd1 << 40) + 65'd181) / 65'd182)};

   typedef struct packed {
      logic              zero;
      logic              czero;
      logic [1:0]        ftype;
      logic [DIV_QW-1:0] val;
   } ctx_type;

   typedef struct packed {
      logic [31:0] x2;
      logic [31:0] x;
      ctx_type     ctx;
   } hr_side_type;

   function automatic logic [FIELD_W-1:0] emit_coef(input logic [39:0] v);
      logic [63:0] w;
      w = ({24'd0, v} << EMIT_UP) + ((64'd1 << EMIT_DN) >> 1);
      w = w >> EMIT_DN;
      return (w > 64'hFFFF_FFFF) ? '1 : w[FIELD_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/svfc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a context word alongside.
`timescale 1ns / 1ps
`default_nettype none
module svfc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire logic [svfc_pkg::DIV_DW-1:0] in_dividend,
   input  wire logic [svfc_pkg::DIV_VW-1:0] in_divisor,
   input  wire svfc_pkg::ctx_type           in_ctx,
   output logic                             out_valid,
   output logic [svfc_pkg::DIV_QW-1:0]      out_quot,
   output svfc_pkg::ctx_type                out_ctx
);
   import svfc_pkg::*;

   logic              v_ff   [DIV_QW];
   logic [DIV_VW-1:0] rem_ff [DIV_QW];
   logic [DIV_QW-1:0] lq_ff  [DIV_QW];
   logic [DIV_VW-1:0] dvs_ff [DIV_QW];
   ctx_type           ctx_ff [DIV_QW];

   genvar i;
   generate
      for (i = 0; i < DIV_QW; i++) begin : g_stage
         logic              pv;
         logic [DIV_VW-1:0] prem;
         logic [DIV_VW-1:0] pdvs;
         logic [DIV_QW-1:0] plq;
         ctx_type           pctx;
         logic [DIV_VW:0]   trial;
         logic [DIV_VW:0]   diff;
         logic              ge;

         if (i == 0) begin : g_first
            assign pv   = in_valid;
            assign prem = {{(DIV_VW - (DIV_DW - DIV_QW)){1'b0}},
                           in_dividend[DIV_DW-1:DIV_QW]};
            assign plq  = in_dividend[DIV_QW-1:0];
            assign pdvs = in_divisor;
            assign pctx = in_ctx;
         end else begin : g_next
            assign pv   = v_ff[i-1];
            assign prem = rem_ff[i-1];
            assign plq  = lq_ff[i-1];
            assign pdvs = dvs_ff[i-1];
            assign pctx = ctx_ff[i-1];
         end

         assign trial = {prem, plq[DIV_QW-1]};
         assign diff  = trial - {1'b0, pdvs};
         assign ge    = (trial >= {1'b0, pdvs});

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (adv) begin
               v_ff[i] <= pv;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i] <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
               lq_ff[i]  <= {plq[DIV_QW-2:0], ge};
               dvs_ff[i] <= pdvs;
               ctx_ff[i] <= pctx;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[DIV_QW-1];
   assign out_quot  = lq_ff[DIV_QW-1];
   assign out_ctx   = ctx_ff[DIV_QW-1];

endmodule
`default_nettype wire

>>> rtl/svfc_horner.sv
// Pipelined Horner evaluation of the sine and cosine series, three stages per term.
`timescale 1ns / 1ps
`default_nettype none
module svfc_horner (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire svfc_pkg::hr_side_type in_side,
   output logic                       out_valid,
   output logic [30:0]                out_ts,
   output logic [30:0]                out_tc,
   output svfc_pkg::hr_side_type      out_side
);
   import svfc_pkg::*;

   logic        a_v_ff  [HR_STEPS];
   hr_side_type a_sd_ff [HR_STEPS];
   logic [62:0] a_ps_ff [HR_STEPS];
   logic [62:0] a_pc_ff [HR_STEPS];
   logic        b_v_ff  [HR_STEPS];
   hr_side_type b_sd_ff [HR_STEPS];
   logic [64:0] b_qs_ff [HR_STEPS];
   logic [64:0] b_qc_ff [HR_STEPS];
   logic        c_v_ff  [HR_STEPS];
   hr_side_type c_sd_ff [HR_STEPS];
   logic [30:0] c_ts_ff [HR_STEPS];
   logic [30:0] c_tc_ff [HR_STEPS];

   genvar j;
   generate
      for (j = 0; j < HR_STEPS; j++) begin : g_step
         localparam int D = HR_STEPS - 1 - j;
         logic        pv;
         hr_side_type psd;
         logic [30:0] pts;
         logic [30:0] ptc;
         logic [31:0] qs;
         logic [31:0] qc;
         logic [30:0] ts_in;
         logic [30:0] tc_in;

         if (j == 0) begin : g_first
            assign pv  = in_valid;
            assign psd = in_side;
            assign pts = ONE_Q30;
            assign ptc = ONE_Q30;
         end else begin : g_next
            assign pv  = c_v_ff[j-1];
            assign psd = c_sd_ff[j-1];
            assign pts = c_ts_ff[j-1];
            assign ptc = c_tc_ff[j-1];
         end

         assign qs    = 32'(b_qs_ff[j] >> SIN_SH[D]);
         assign qc    = 32'(b_qc_ff[j] >> COS_SH[D]);
         assign ts_in = ONE_Q30 - ((qs > {1'b0, ONE_Q30}) ? ONE_Q30 : qs[30:0]);
         assign tc_in = ONE_Q30 - ((qc > {1'b0, ONE_Q30}) ? ONE_Q30 : qc[30:0]);

         always_ff @(posedge clock) begin
            if (reset) begin
               a_v_ff[j] <= 1'b0;
               b_v_ff[j] <= 1'b0;
               c_v_ff[j] <= 1'b0;
            end else if (adv) begin
               a_v_ff[j] <= pv;
               b_v_ff[j] <= a_v_ff[j];
               c_v_ff[j] <= b_v_ff[j];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               a_sd_ff[j] <= psd;
               a_ps_ff[j] <= 63'(psd.x2) * 63'(pts);
               a_pc_ff[j] <= 63'(psd.x2) * 63'(ptc);
               b_sd_ff[j] <= a_sd_ff[j];
               b_qs_ff[j] <= 65'(a_ps_ff[j][61:30]) * 65'(SIN_RCP[D]);
               b_qc_ff[j] <= 65'(a_pc_ff[j][61:30]) * 65'(COS_RCP[D]);
               c_sd_ff[j] <= b_sd_ff[j];
               c_ts_ff[j] <= ts_in;
               c_tc_ff[j] <= tc_in;
            end
         end
      end
   endgenerate

   assign out_valid = c_v_ff[HR_STEPS-1];
   assign out_ts    = c_ts_ff[HR_STEPS-1];
   assign out_tc    = c_tc_ff[HR_STEPS-1];
   assign out_side  = c_sd_ff[HR_STEPS-1];

endmodule
`default_nettype wire

>>> rtl/crossover_svf_coefficient_calc_core.sv
// Top level of the crossover state-variable filter coefficient calculator.
// Requests pass three 40-stage dividers, the 21-stage series unit and the multiply stages.
// Throughput: one beat per cycle; the whole pipeline holds while the result beat is stalled.
// Reset clears all valid bits and loads the sample rate register with 44100.
`timescale 1ns / 1ps
`default_nettype none
module crossover_svf_coefficient_calc_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [svfc_pkg::FS_W-1:0]   csr_wr_data,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [23:0]                 req_tdata,  // corner_freq_hz[16:0], zero pad
   input  wire logic [1:0]                  req_tuser,  // filter_type[1:0]
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [135:0]                     rsp_tdata   // coef_a1, coef_a2, coef_a3, damping_k,
                                                        // section_count[129:128], zero pad
);
   import svfc_pkg::*;

   logic              adv;
   logic [FS_W-1:0]   fs_ff;

   logic              v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic              v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff;
   logic              out_v_ff;
   logic [FREQ_W-1:0] f0_ff;
   logic [1:0]        t0_ff;
   ctx_type           ctx1_ff, ctx2_ff, ctx3_ff, ctx4_ff, ctx5_ff, ctx6_ff;
   ctx_type           ctx7_ff, ctx8_ff, ctx9_ff, ctx10_ff, ctx11_ff, ctx12_ff, ctx13_ff, ctx14_ff;
   logic [21:0]       num1_ff;
   logic [53:0]       np2_ff;
   logic [DIV_DW-1:0] dvd3_ff, dvd10_ff;
   logic [DIV_VW-1:0] dvs3_ff, dvs10_ff, d9_ff;
   logic [63:0]       xx4_ff;
   logic [31:0]       x4_ff, x5_ff, x2_5_ff;
   logic [62:0]       sp6_ff;
   logic [30:0]       c6_ff;
   logic [39:0]       g7_ff;
   logic [40:0]       gk7_ff;
   logic [65:0]       ph8_ff;
   logic [55:0]       pl8_ff;
   logic [39:0]       a1_11_ff, a1_12_ff, a1_13_ff, a1_14_ff;
   logic [56:0]       ph11_ff;
   logic [46:0]       pl11_ff;
   logic [39:0]       a2_12_ff, a2_13_ff, a2_14_ff;
   logic [64:0]       ph13_ff;
   logic [54:0]       pl13_ff;
   logic [39:0]       a3_14_ff;
   logic [135:0]      out_data_ff;

   logic              zero_in;
   logic [FREQ_W-1:0] fl;
   logic [21:0]       f20, fs9, num_in;
   ctx_type           ctx1_in;

   logic              vx;
   logic [DIV_QW-1:0] qx;
   ctx_type           ctxx;
   hr_side_type       hr_in, hr_out;
   logic              vh;
   logic [30:0]       ts, tc;
   logic              vg;
   logic [DIV_QW-1:0] qg;
   ctx_type           ctxg, ctx6_div, ctx7_in;
   logic [39:0]       g_in;
   logic [31:0]       k_in;
   logic              va;
   logic [DIV_QW-1:0] qa;
   ctx_type           ctxa;
   logic [31:0]       k_out;
   logic [1:0]        cnt_out;
   logic [135:0]      out_data_in;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FS_RESET;
      end else if (csr_wr_en) begin
         fs_ff <= csr_wr_data;
      end
   end

   // Front end: clamp, angle numerator and divider operands.
   assign zero_in = (f0_ff == '0) || (t0_ff == FT_NONE) || (fs_ff == '0);
   assign fl      = (f0_ff < FREQ_MIN) ? FREQ_MIN : f0_ff;
   assign f20     = 22'(fl) * 22'd20;
   assign fs9     = 22'(fs_ff) * 22'd9;
   assign num_in  = (f20 > fs9) ? fs9 : f20;

   always_comb begin
      ctx1_in       = '0;
      ctx1_in.zero  = zero_in;
      ctx1_in.ftype = t0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f0_ff   <= req_tdata[FREQ_W-1:0];
         t0_ff   <= req_tuser;
         ctx1_ff <= ctx1_in;
         num1_ff <= num_in;
         ctx2_ff <= ctx1_ff;
         np2_ff  <= 54'(num1_ff) * 54'(PI_Q30);
         ctx3_ff <= ctx2_ff;
         dvd3_ff <= 61'(np2_ff) + 61'(fs_ff) * 61'd10;
         dvs3_ff <= 38'(fs_ff) * 38'd20;
      end
   end

   svfc_div u_div_angle (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (v3_ff),
      .in_dividend (dvd3_ff),
      .in_divisor  (dvs3_ff),
      .in_ctx      (ctx3_ff),
      .out_valid   (vx),
      .out_quot    (qx),
      .out_ctx     (ctxx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= vx;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx4_ff <= ctxx;
         x4_ff   <= qx[31:0];
         xx4_ff  <= 64'(qx[31:0]) * 64'(qx[31:0]);
         ctx5_ff <= ctx4_ff;
         x5_ff   <= x4_ff;
         x2_5_ff <= 32'((xx4_ff + (64'd1 << 29)) >> 30);
      end
   end

   always_comb begin
      hr_in.x2  = x2_5_ff;
      hr_in.x   = x5_ff;
      hr_in.ctx = ctx5_ff;
   end

   svfc_horner u_horner (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_side   (hr_in),
      .out_valid (vh),
      .out_ts    (ts),
      .out_tc    (tc),
      .out_side  (hr_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= vh;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx6_ff <= hr_out.ctx;
         sp6_ff  <= 63'(hr_out.x) * 63'(ts);
         c6_ff   <= tc;
      end
   end

   always_comb begin
      ctx6_div       = ctx6_ff;
      ctx6_div.czero = (c6_ff == '0);
   end

   svfc_div u_div_tan (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (v6_ff),
      .in_dividend ({sp6_ff[60:30], 30'd0}),
      .in_divisor  (38'(c6_ff)),
      .in_ctx      (ctx6_div),
      .out_valid   (vg),
      .out_quot    (qg),
      .out_ctx     (ctxg)
   );

   assign g_in = ctxg.czero ? (40'd1 << 36) : qg;
   assign k_in = (ctxg.ftype == FT_LR2) ? TWO_Q30 : SQRT2_Q30;

   always_comb begin
      ctx7_in     = ctxg;
      ctx7_in.val = g_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (adv) begin
         v7_ff  <= vg;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx7_ff  <= ctx7_in;
         g7_ff    <= g_in;
         gk7_ff   <= 41'(g_in) + 41'(k_in);
         ctx8_ff  <= ctx7_ff;
         ph8_ff   <= 66'(g7_ff[39:15]) * 66'(gk7_ff);
         pl8_ff   <= 56'(g7_ff[14:0]) * 56'(gk7_ff);
         ctx9_ff  <= ctx8_ff;
         d9_ff    <= 38'((ph8_ff + 66'(pl8_ff >> 15)) >> 15) + 38'(ONE_Q30);
         ctx10_ff <= ctx9_ff;
         dvd10_ff <= (61'd1 << 60) + 61'(d9_ff >> 1);
         dvs10_ff <= d9_ff;
      end
   end

   svfc_div u_div_a1 (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (v10_ff),
      .in_dividend (dvd10_ff),
      .in_divisor  (dvs10_ff),
      .in_ctx      (ctx10_ff),
      .out_valid   (va),
      .out_quot    (qa),
      .out_ctx     (ctxa)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
      end else if (adv) begin
         v11_ff <= va;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx11_ff <= ctxa;
         a1_11_ff <= qa;
         ph11_ff  <= 57'(ctxa.val[39:15]) * 57'(qa[31:0]);
         pl11_ff  <= 47'(ctxa.val[14:0]) * 47'(qa[31:0]);
         ctx12_ff <= ctx11_ff;
         a1_12_ff <= a1_11_ff;
         a2_12_ff <= 40'((ph11_ff + 57'(pl11_ff >> 15)) >> 15);
         ctx13_ff <= ctx12_ff;
         a1_13_ff <= a1_12_ff;
         a2_13_ff <= a2_12_ff;
         ph13_ff  <= 65'(ctx12_ff.val[39:15]) * 65'(a2_12_ff);
         pl13_ff  <= 55'(ctx12_ff.val[14:0]) * 55'(a2_12_ff);
         ctx14_ff <= ctx13_ff;
         a1_14_ff <= a1_13_ff;
         a2_14_ff <= a2_13_ff;
         a3_14_ff <= 40'((ph13_ff + 65'(pl13_ff >> 15)) >> 15);
      end
   end

   always_comb begin
      unique case (ctx14_ff.ftype)
         FT_LR2: begin
            k_out   = TWO_Q30;
            cnt_out = 2'd1;
         end
         FT_BW2: begin
            k_out   = SQRT2_Q30;
            cnt_out = 2'd1;
         end
         FT_LR4: begin
            k_out   = SQRT2_Q30;
            cnt_out = 2'd2;
         end
         default: begin
            k_out   = '0;
            cnt_out = 2'd0;
         end
      endcase
      if (ctx14_ff.zero) begin
         out_data_in = '0;
      end else begin
         out_data_in = {6'd0, cnt_out, emit_coef(40'(k_out)), emit_coef(a3_14_ff),
                        emit_coef(a2_14_ff), emit_coef(a1_14_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v14_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid straight after reset");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the output register is empty");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[129:128] == 2'd0) |-> (rsp_tdata[127:0] == '0))
      else $error("disabled result carries non-zero coefficients");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[129:128] != 2'd3))
      else $error("section count out of range");

endmodule
`default_nettype wire
